>>> src/accel_tile_size_planner_top_defines.svh
// Assertion macros for the checker of the tile size planner.
// No dependencies; included by the checker module.
`ifndef ACCEL_TILE_SIZE_PLANNER_TOP_DEFINES_SVH
`define ACCEL_TILE_SIZE_PLANNER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ATSP_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("tile planner check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ATSP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("tile planner check failed");

`endif

>>> src/atsp_pkg.sv
// Package of the tile size planner: field widths, register indexes and the
// request and response types of the shared divider. No dependencies.
`timescale 1ns / 1ps

package atsp_pkg;

  localparam int unsigned ExtW    = 13;
  localparam int unsigned TileW   = 9;
  localparam int unsigned SmallW  = 4;
  localparam int unsigned CluW    = 5;
  localparam int unsigned MaskW   = 16;
  localparam int unsigned KibW    = 13;
  localparam int unsigned CapW    = 23;

  localparam int unsigned MulAW   = 24;
  localparam int unsigned MulBW   = 18;
  localparam int unsigned ProdW   = MulAW + MulBW;

  localparam int unsigned DivW     = ExtW + 1;
  localparam int unsigned DivSteps = DivW;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  localparam int unsigned InDataW  = 80;
  localparam int unsigned OutDataW = 104;

  localparam logic [1:0] REG_PE_ROWS  = 2'd0;
  localparam logic [1:0] REG_PE_COLS  = 2'd1;
  localparam logic [1:0] REG_SCRATCH  = 2'd2;
  localparam logic [1:0] REG_CLUSTERS = 2'd3;

  localparam logic [TileW-1:0] PE_ROWS_RST  = 9'd16;
  localparam logic [TileW-1:0] PE_COLS_RST  = 9'd16;
  localparam logic [KibW-1:0]  SCRATCH_RST  = 13'd256;
  localparam logic [CluW-1:0]  CLUSTERS_RST = 5'd4;

  typedef struct packed {
    logic            start;
    logic [DivW-1:0] numer;
    logic [ExtW-1:0] denom;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [DivW-1:0] quot;
  } div_rsp_t;

endpackage

>>> src/atsp_mul.sv
// Shared multiplier of the tile size planner with a registered product.
// Depends on atsp_pkg for the operand widths.
`timescale 1ns / 1ps

module atsp_mul import atsp_pkg::*; (
  input  logic             clk_i,
  input  logic [MulAW-1:0] a_i,
  input  logic [MulBW-1:0] b_i,
  output logic [ProdW-1:0] prod_o
);

  logic [ProdW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= ProdW'(a_i) * ProdW'(b_i);
  end

  assign prod_o = prod_q;

endmodule

>>> src/atsp_div.sv
// Restoring divider of the tile size planner, one quotient bit per cycle.
// Depends on atsp_pkg for the request and response types.
`timescale 1ns / 1ps

module atsp_div import atsp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [DivW-1:0]    num_q;
  logic [DivW-1:0]    rem_q;
  logic [ExtW-1:0]    den_q;
  logic [DivCntW-1:0] cnt_q;
  logic               run_q;
  logic               done_q;
  logic [DivW-1:0]    trial;
  logic               take;

  assign trial = {rem_q[DivW-2:0], num_q[DivW-1]};
  assign take  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      run_q  <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (run_q) begin
      if (cnt_q == DivCntW'(DivSteps - 1)) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q + 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= req_i.numer;
      rem_q <= '0;
      den_q <= req_i.denom;
    end else if (run_q) begin
      rem_q <= take ? (trial - {1'b0, den_q}) : trial;
      num_q <= {num_q[DivW-2:0], take};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = num_q;

endmodule

>>> src/accel_tile_size_planner_top.sv
// Top level of the tile size planner: register port, sequencer and payload.
// Depends on atsp_pkg, atsp_mul and atsp_div.
//
//  channel   direction  handshake                    payload
//  s_axis    in         s_axis_tvalid/s_axis_tready  layer description
//  m_axis    out        m_axis_tvalid/m_axis_tready  tile plan
//  apb       in         psel/penable, pready high    four planning registers
//
// A layer runs from acceptance to a valid plan through 6 setup passes, 13
// search steps of 4 passes each through the shared multiplier, and three
// ceiling divisions in the one-bit-per-cycle divider.
// The input is ready only while the sequencer is idle; a finished plan waits
// in the output register, and the next layer can be taken meanwhile.
// Reset is asynchronous and active low and restores the register defaults.
`timescale 1ns / 1ps

module accel_tile_size_planner_top import atsp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // rows_extent, cols_extent, search_extent, out_width, in_width,
  // kernel_height, kernel_width, stride_height, zero fill
  input  logic [InDataW-1:0]  s_axis_tdata,
  // func, is_int8
  input  logic [1:0]          s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // tile_rows, tile_cols, tile_search, tile_width, extent_first,
  // extent_second, extent_third, clusters_used, cluster_bits
  output logic [OutDataW-1:0] m_axis_tdata,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SETUP = 3'd1;
  localparam logic [2:0] ST_SRCH  = 3'd2;
  localparam logic [2:0] ST_DIVS  = 3'd3;
  localparam logic [2:0] ST_DIVW  = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;

  localparam logic [2:0] SETUP_LAST = 3'd5;
  localparam logic [1:0] PH_LAST    = 2'd3;
  localparam logic [3:0] BIT_TOP    = 4'(ExtW - 1);
  localparam logic [1:0] DIV_ROWS   = 2'd0;
  localparam logic [1:0] DIV_COLS   = 2'd1;
  localparam logic [1:0] DIV_SRCH   = 2'd2;

  logic [TileW-1:0] pe_rows_q, pe_cols_q;
  logic [KibW-1:0]  scratch_q;
  logic [CluW-1:0]  clusters_q;

  logic [2:0] state_q, state_d;
  logic [2:0] step_q, step_d;
  logic [1:0] phase_q, phase_d;
  logic [3:0] bit_q, bit_d;
  logic [1:0] div_idx_q, div_idx_d;
  logic       out_valid_q, out_valid_d;

  logic                gemm_q, int8_q;
  logic [ExtW-1:0]     rx_q, cx_q, sx_q, ow_q, iw_q;
  logic [SmallW-1:0]   kh_q, kw_q, sh_q;
  logic [TileW-1:0]    tr_q, tc_q;
  logic [22:0]         p_q, q_q;
  logic [17:0]         trtc_q;
  logic [26:0]         fixed_q;
  logic [ProdW-1:0]    acc_q;
  logic [ExtW-1:0]     res_q;
  logic [ExtW-1:0]     qr_q, qc_q, qs_q;
  logic [OutDataW-1:0] out_data_q;

  logic             s_accept, cfg_wr, load_out;
  logic [MulAW-1:0] mul_a;
  logic [MulBW-1:0] mul_b;
  logic [ProdW-1:0] prod;
  logic [ExtW-1:0]  cand, ts;
  logic [17:0]      rows, inrows;
  logic [ProdW-1:0] total;
  logic [CapW-1:0]  cap;
  logic             fits;
  div_req_t         div_req;
  div_rsp_t         div_rsp;
  logic [ExtW-1:0]  div_a, div_d, div_q;
  logic [ExtW-1:0]  e1, e2, e3, e_clu;
  logic [CluW-1:0]  cu;
  logic [MaskW-1:0] mask;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_accept = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pe_rows_q  <= PE_ROWS_RST;
      pe_cols_q  <= PE_COLS_RST;
      scratch_q  <= SCRATCH_RST;
      clusters_q <= CLUSTERS_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_PE_ROWS:  pe_rows_q  <= pwdata[TileW-1:0];
        REG_PE_COLS:  pe_cols_q  <= pwdata[TileW-1:0];
        REG_SCRATCH:  scratch_q  <= pwdata[KibW-1:0];
        REG_CLUSTERS: clusters_q <= pwdata[CluW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_PE_ROWS:  prdata = 32'(pe_rows_q);
      REG_PE_COLS:  prdata = 32'(pe_cols_q);
      REG_SCRATCH:  prdata = 32'(scratch_q);
      REG_CLUSTERS: prdata = 32'(clusters_q);
      default:      prdata = '0;
    endcase
  end

  assign cand   = res_q | (ExtW'(1) << bit_q);
  assign rows   = 18'(prod[16:0]) + 18'(kh_q);
  assign inrows = (rows == '0) ? '0 : rows - 18'd1;
  assign total  = acc_q + prod;
  assign cap    = {scratch_q, 10'd0};
  assign fits   = (cand <= sx_q) && (total <= ProdW'(cap));
  assign ts     = (res_q == '0) ? ExtW'(1) : res_q;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_SETUP: begin
        case (step_q)
          3'd0: begin
            mul_a = MulAW'(iw_q);
            mul_b = MulBW'(tc_q);
          end
          3'd1: begin
            mul_a = MulAW'(ow_q);
            mul_b = MulBW'(tr_q);
          end
          3'd2: begin
            mul_a = MulAW'(tr_q);
            mul_b = MulBW'(tc_q);
          end
          3'd3: begin
            mul_a = prod[MulAW-1:0];
            mul_b = MulBW'(kh_q);
          end
          3'd4: begin
            mul_a = prod[MulAW-1:0];
            mul_b = MulBW'(kw_q);
          end
          default: ;
        endcase
      end
      ST_SRCH: begin
        case (phase_q)
          2'd0: begin
            mul_a = MulAW'(cand);
            mul_b = MulBW'(sh_q);
          end
          2'd1: begin
            mul_a = MulAW'(p_q);
            mul_b = inrows;
          end
          2'd2: begin
            mul_a = MulAW'(q_q);
            mul_b = MulBW'(cand);
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  atsp_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  always_comb begin
    case (div_idx_q)
      DIV_ROWS: begin
        div_a = rx_q;
        div_d = ExtW'(tr_q);
      end
      DIV_COLS: begin
        div_a = cx_q;
        div_d = ExtW'(tc_q);
      end
      default: begin
        div_a = sx_q;
        div_d = ts;
      end
    endcase
  end

  assign div_req.start = (state_q == ST_DIVS);
  assign div_req.numer = DivW'(div_a) + DivW'(div_d) - DivW'(1);
  assign div_req.denom = div_d;
  assign div_q = (div_d == '0) ? '0 : div_rsp.quot[ExtW-1:0];

  atsp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    phase_d     = phase_q;
    bit_d       = bit_q;
    div_idx_d   = div_idx_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    load_out    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (s_accept) begin
          state_d = ST_SETUP;
          step_d  = '0;
        end
      end
      ST_SETUP: begin
        if (step_q == SETUP_LAST) begin
          state_d = ST_SRCH;
          phase_d = '0;
          bit_d   = BIT_TOP;
        end else begin
          step_d = step_q + 3'd1;
        end
      end
      ST_SRCH: begin
        phase_d = phase_q + 2'd1;
        if (phase_q == PH_LAST) begin
          if (bit_q == '0) begin
            state_d   = ST_DIVS;
            div_idx_d = DIV_ROWS;
          end else begin
            bit_d = bit_q - 4'd1;
          end
        end
      end
      ST_DIVS: begin
        state_d = ST_DIVW;
      end
      ST_DIVW: begin
        if (div_rsp.done) begin
          if (div_idx_q == DIV_SRCH) begin
            state_d = ST_FIN;
          end else begin
            div_idx_d = div_idx_q + 2'd1;
            state_d   = ST_DIVS;
          end
        end
      end
      ST_FIN: begin
        if (!out_valid_q || m_axis_tready) begin
          load_out    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      phase_q     <= '0;
      bit_q       <= '0;
      div_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      phase_q     <= phase_d;
      bit_q       <= bit_d;
      div_idx_q   <= div_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign e1    = gemm_q ? qr_q : qs_q;
  assign e2    = gemm_q ? qc_q : qr_q;
  assign e3    = gemm_q ? qs_q : qc_q;
  assign e_clu = gemm_q ? qr_q : qr_q;
  assign cu    = (ExtW'(clusters_q) < e_clu) ? clusters_q : e_clu[CluW-1:0];
  assign mask  = cu[CluW-1] ? '1 : MaskW'((32'd1 << cu[CluW-2:0]) - 32'd1);

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      gemm_q <= s_axis_tuser[0];
      int8_q <= s_axis_tuser[1];
      rx_q   <= s_axis_tdata[12:0];
      cx_q   <= s_axis_tdata[25:13];
      sx_q   <= s_axis_tdata[38:26];
      ow_q   <= s_axis_tdata[51:39];
      iw_q   <= s_axis_tdata[64:52];
      kh_q   <= s_axis_tdata[68:65];
      kw_q   <= s_axis_tdata[72:69];
      sh_q   <= s_axis_tdata[76:73];
      tr_q   <= (s_axis_tdata[12:0] < ExtW'(pe_rows_q)) ?
                s_axis_tdata[8:0] : pe_rows_q;
      tc_q   <= (s_axis_tdata[25:13] < ExtW'(pe_cols_q)) ?
                s_axis_tdata[21:13] : pe_cols_q;
      res_q  <= '0;
    end
    if (state_q == ST_SETUP) begin
      case (step_q)
        3'd1: p_q <= gemm_q ? '0 :
                     (int8_q ? {1'b0, prod[21:0]} : {prod[21:0], 1'b0});
        3'd2: q_q <= int8_q ? {1'b0, prod[21:0]} : {prod[21:0], 1'b0};
        3'd3: trtc_q <= prod[17:0];
        3'd5: begin
          if (gemm_q) begin
            fixed_q <= int8_q ? 27'({trtc_q, 1'b0}) : 27'({trtc_q, 2'b00});
            q_q     <= int8_q ? 23'(10'(tr_q) + 10'(tc_q)) :
                       23'({10'(tr_q) + 10'(tc_q), 1'b0});
          end else begin
            fixed_q <= int8_q ? {1'b0, prod[25:0]} : {prod[25:0], 1'b0};
          end
        end
        default: ;
      endcase
    end
    if (state_q == ST_SRCH) begin
      if (phase_q == 2'd2) begin
        acc_q <= prod + ProdW'(fixed_q);
      end
      if (phase_q == PH_LAST && fits) begin
        res_q <= cand;
      end
    end
    if (state_q == ST_DIVW && div_rsp.done) begin
      case (div_idx_q)
        DIV_ROWS: qr_q <= div_q;
        DIV_COLS: qc_q <= div_q;
        default:  qs_q <= div_q;
      endcase
    end
    if (load_out) begin
      out_data_q <= {mask, cu, e3, e2, e1, gemm_q ? ExtW'(0) : ow_q, ts, tc_q, tr_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

>>> src/atsp_checker.sv
// Port-level checks of the tile size planner, bound to the top level.
// Depends on atsp_pkg and the assertion macros in the defines header.
`timescale 1ns / 1ps
`include "accel_tile_size_planner_top_defines.svh"

module atsp_checker import atsp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [OutDataW-1:0] m_axis_tdata
);

  logic in_txn;

  assign in_txn = s_axis_tvalid && s_axis_tready;

  // The sequencer is busy right after it takes a layer.
  `ATSP_ASSERT_NEXT(a_busy_after_txn, clk_i, rst_ni, in_txn, !s_axis_tready)
  // A plan never shows up in the cycle right after a layer is taken.
  `ATSP_ASSERT_NEXT(a_no_instant_plan, clk_i, rst_ni, in_txn, !$rose(m_axis_tvalid))
  // The chosen search tile is never zero.
  `ATSP_ASSERT_SAME(a_tile_nonzero, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[30:18] != '0)
  // A stalled plan holds its value.
  `ATSP_ASSERT_NEXT(a_plan_holds, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
                    m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind accel_tile_size_planner_top atsp_checker u_atsp_checker (.*);

>>> tb/testbench.sv
// Self-checking testbench for the tile size planner: directed layers, then random
// layers across several array settings, each plan checked with a table or a predictor.
// Depends on atsp_pkg and accel_tile_size_planner_top.
`timescale 1ns / 1ps

module testbench;
  import atsp_pkg::*;

  typedef enum logic {
    OP_CONV2D = 1'b0,
    OP_GEMM   = 1'b1
  } op_e;

  typedef struct packed {
    op_e               func;
    logic              is_int8;
    logic [ExtW-1:0]   rows_extent;
    logic [ExtW-1:0]   cols_extent;
    logic [ExtW-1:0]   search_extent;
    logic [ExtW-1:0]   out_width;
    logic [ExtW-1:0]   in_width;
    logic [SmallW-1:0] kernel_height;
    logic [SmallW-1:0] kernel_width;
    logic [SmallW-1:0] stride_height;
  } layer_t;

  typedef struct packed {
    logic [TileW-1:0] tile_rows;
    logic [TileW-1:0] tile_cols;
    logic [ExtW-1:0]  tile_search;
    logic [ExtW-1:0]  tile_width;
    logic [ExtW-1:0]  extent_first;
    logic [ExtW-1:0]  extent_second;
    logic [ExtW-1:0]  extent_third;
    logic [CluW-1:0]  clusters_used;
    logic [MaskW-1:0] cluster_bits;
  } plan_t;

  typedef struct packed {
    logic [TileW-1:0] pe_rows;
    logic [TileW-1:0] pe_cols;
    logic [KibW-1:0]  scratch_kib;
    logic [CluW-1:0]  cluster_count;
  } array_cfg_t;

  typedef struct packed {
    layer_t layer;
    logic   known;
    plan_t  plan;
  } layer_row_t;

  localparam int NumDirected = 16;
  localparam int NumPhases = 9;
  localparam int LayersPerPhase = 120;

  localparam layer_row_t DirectedLayers [NumDirected] = '{
    '{'{OP_GEMM, 1, 1, 1, 1, 1, 1, 1, 1, 1}, 1, '{1, 1, 1, 0, 1, 1, 1, 1, 1}},
    '{'{OP_CONV2D, 1, 1, 1, 1, 1, 1, 1, 1, 1}, 1, '{1, 1, 1, 1, 1, 1, 1, 1, 1}},
    '{'{OP_GEMM, 0, 16, 16, 0, 1, 1, 1, 1, 1}, 1, '{16, 16, 1, 0, 1, 1, 0, 1, 1}},
    '{'{OP_GEMM, 1, 0, 1, 5, 1, 1, 1, 1, 1}, 1, '{0, 1, 5, 0, 0, 1, 1, 0, 0}},
    '{'{OP_CONV2D, 0, 4096, 4096, 4096, 4096, 4096, 15, 15, 8}, 1,
      '{16, 16, 1, 4096, 4096, 256, 256, 4, 16'h000F}},
    '{'{OP_CONV2D, 0, 0, 0, 0, 0, 0, 0, 0, 0}, 1, '{0, 0, 1, 0, 0, 0, 0, 0, 0}},
    '{'{OP_CONV2D, 1, 8, 8, 20, 3, 5, 0, 0, 0}, 0, '0},
    '{'{OP_CONV2D, 1, 8191, 8191, 8191, 8191, 8191, 15, 15, 15}, 0, '0},
    '{'{OP_GEMM, 0, 8191, 8191, 8191, 8191, 8191, 15, 15, 15}, 0, '0},
    '{'{OP_GEMM, 1, 16, 16, 4096, 1, 1, 1, 1, 1}, 0, '0},
    '{'{OP_CONV2D, 1, 16, 16, 64, 32, 34, 3, 3, 1}, 0, '0},
    '{'{OP_CONV2D, 0, 3, 200, 100, 100, 102, 3, 3, 2}, 0, '0},
    '{'{OP_GEMM, 0, 100, 37, 777, 5, 9, 2, 2, 2}, 0, '0},
    '{'{OP_CONV2D, 1, 64, 3, 224, 224, 226, 7, 7, 2}, 0, '0},
    '{'{OP_CONV2D, 0, 32, 32, 56, 56, 58, 1, 1, 1}, 0, '0},
    '{'{OP_GEMM, 1, 5000, 300, 2048, 0, 0, 0, 0, 0}, 0, '0}
  };

  localparam array_cfg_t ExtremeArrays [4] = '{
    '{1, 1, 1, 1},
    '{256, 256, 4096, 16},
    '{511, 511, 8191, 31},
    '{0, 0, 0, 0}
  };

  localparam logic [ExtW-1:0] BoundaryExtents [5] = '{0, 1, 4095, 4096, 8191};

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  // rows_extent, cols_extent, search_extent, out_width, in_width,
  // kernel_height, kernel_width, stride_height, zero fill
  logic [InDataW-1:0]  s_axis_tdata;
  // func, is_int8
  logic [1:0]          s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  // tile_rows, tile_cols, tile_search, tile_width, extent_first,
  // extent_second, extent_third, clusters_used, cluster_bits
  logic [OutDataW-1:0] m_axis_tdata;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [3:0]          paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  array_cfg_t array_cfg;
  plan_t      expected_plans [$];
  int         plan_errors;
  logic       steady_tail;

  accel_tile_size_planner_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  function automatic longint unsigned min_of(longint unsigned a, longint unsigned b);
    return (a < b) ? a : b;
  endfunction

  function automatic longint unsigned div_round_up(longint unsigned num,
                                                   longint unsigned den);
    return (den == 0) ? 0 : (num + den - 1) / den;
  endfunction

  function automatic plan_t plan_layer(layer_t l);
    longint unsigned bpe, tr, tc, cap, fixed, ts, t, height, in_rows, need;
    longint unsigned ext_a, ext_b, ext_c, used, mask;
    plan_t p;
    bpe = l.is_int8 ? 1 : 2;
    tr = min_of(l.rows_extent, array_cfg.pe_rows);
    tc = min_of(l.cols_extent, array_cfg.pe_cols);
    cap = array_cfg.scratch_kib;
    cap = cap * 1024;
    if (l.func == OP_GEMM) begin
      fixed = tr * tc * bpe * 2;
    end else begin
      fixed = tr * tc * l.kernel_height * l.kernel_width * bpe;
    end
    ts = 1;
    for (t = l.search_extent; t >= 1; t--) begin
      if (l.func == OP_GEMM) begin
        need = tr * t * bpe + t * tc * bpe + fixed;
      end else begin
        height = t * l.stride_height + l.kernel_height;
        in_rows = (height == 0) ? 0 : height - 1;
        need = tc * in_rows * l.in_width * bpe + fixed + tr * t * l.out_width * bpe;
      end
      if (need <= cap) begin
        ts = t;
        break;
      end
    end
    if (l.func == OP_GEMM) begin
      ext_a = div_round_up(l.rows_extent, tr);
      ext_b = div_round_up(l.cols_extent, tc);
      ext_c = div_round_up(l.search_extent, ts);
      used = min_of(array_cfg.cluster_count, ext_a);
    end else begin
      ext_a = div_round_up(l.search_extent, ts);
      ext_b = div_round_up(l.rows_extent, tr);
      ext_c = div_round_up(l.cols_extent, tc);
      used = min_of(array_cfg.cluster_count, ext_b);
    end
    mask = (used >= 16) ? 64'hFFFF : (64'd1 << used) - 1;
    p.tile_rows = tr[TileW-1:0];
    p.tile_cols = tc[TileW-1:0];
    p.tile_search = ts[ExtW-1:0];
    p.tile_width = (l.func == OP_GEMM) ? '0 : l.out_width;
    p.extent_first = ext_a[ExtW-1:0];
    p.extent_second = ext_b[ExtW-1:0];
    p.extent_third = ext_c[ExtW-1:0];
    p.clusters_used = used[CluW-1:0];
    p.cluster_bits = mask[MaskW-1:0];
    return p;
  endfunction

  function automatic logic [ExtW-1:0] pick_extent();
    case ($urandom_range(0, 9))
      0: return ExtW'($urandom_range(0, 8191));
      1: return BoundaryExtents[$urandom_range(0, 4)];
      2, 3: return ExtW'($urandom_range(1, 4096));
      4, 5, 6: return ExtW'($urandom_range(1, 256));
      default: return ExtW'($urandom_range(1, 32));
    endcase
  endfunction

  function automatic logic [SmallW-1:0] pick_small();
    if ($urandom_range(0, 3) == 0) begin
      return SmallW'($urandom_range(0, 15));
    end
    return SmallW'($urandom_range(1, 5));
  endfunction

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      plan_errors++;
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_PE_ROWS:  array_cfg.pe_rows = value[TileW-1:0];
      REG_PE_COLS:  array_cfg.pe_cols = value[TileW-1:0];
      REG_SCRATCH:  array_cfg.scratch_kib = value[KibW-1:0];
      REG_CLUSTERS: array_cfg.cluster_count = value[CluW-1:0];
      default: ;
    endcase
  endtask

  task automatic send_layer(input layer_t l, input plan_t want);
    if (!steady_tail && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {{(InDataW - 77){1'b0}}, l.stride_height, l.kernel_width,
                     l.kernel_height, l.in_width, l.out_width, l.search_extent,
                     l.cols_extent, l.rows_extent};
    s_axis_tuser <= {l.is_int8, l.func};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_plans.push_back(want);
  endtask

  task automatic drain_plans();
    s_axis_tvalid <= 1'b0;
    while (expected_plans.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : plan_checker
    int    stall_left;
    int    hold_left;
    int    plans_seen;
    logic  ready_next;
    plan_t seen;
    plan_t want;
    stall_left = 0;
    hold_left = 0;
    plans_seen = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        plans_seen++;
        {seen.cluster_bits, seen.clusters_used, seen.extent_third, seen.extent_second,
         seen.extent_first, seen.tile_width, seen.tile_search, seen.tile_cols,
         seen.tile_rows} = m_axis_tdata;
        if (expected_plans.size() == 0) begin
          $error("Plan transaction arrived with no layer outstanding.");
          plan_errors++;
        end else begin
          want = expected_plans.pop_front();
          check_field("tile_rows", want.tile_rows, seen.tile_rows);
          check_field("tile_cols", want.tile_cols, seen.tile_cols);
          check_field("tile_search", want.tile_search, seen.tile_search);
          check_field("tile_width", want.tile_width, seen.tile_width);
          check_field("extent_first", want.extent_first, seen.extent_first);
          check_field("extent_second", want.extent_second, seen.extent_second);
          check_field("extent_third", want.extent_third, seen.extent_third);
          check_field("clusters_used", want.clusters_used, seen.clusters_used);
          check_field("cluster_bits", want.cluster_bits, seen.cluster_bits);
        end
        // Hold the output once for long enough that the planner backs up.
        if (plans_seen == 30) hold_left = 600;
      end
      if (hold_left > 0) begin
        hold_left--;
        ready_next = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        ready_next = 1'b0;
      end else if (!steady_tail && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 5) - 1;
        ready_next = 1'b0;
      end else begin
        ready_next = 1'b1;
      end
      m_axis_tready <= ready_next;
    end
  end

  initial begin
    layer_t l;
    array_cfg_t c;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    m_axis_tready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    plan_errors = 0;
    steady_tail = 1'b0;
    array_cfg = '{PE_ROWS_RST, PE_COLS_RST, SCRATCH_RST, CLUSTERS_RST};
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirectedLayers[i]) begin
      send_layer(DirectedLayers[i].layer, DirectedLayers[i].known ?
                 DirectedLayers[i].plan : plan_layer(DirectedLayers[i].layer));
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      if (ph > 0) begin
        drain_plans();
        if (ph <= 4) begin
          c = ExtremeArrays[ph - 1];
        end else begin
          c.pe_rows = ($urandom_range(0, 3) == 0) ? TileW'($urandom_range(0, 511)) :
                      TileW'($urandom_range(1, 256));
          c.pe_cols = ($urandom_range(0, 3) == 0) ? TileW'($urandom_range(0, 511)) :
                      TileW'($urandom_range(1, 256));
          c.scratch_kib = ($urandom_range(0, 3) == 0) ? KibW'($urandom_range(0, 8191)) :
                          KibW'($urandom_range(1, 4096));
          c.cluster_count = ($urandom_range(0, 3) == 0) ? CluW'($urandom_range(0, 31)) :
                            CluW'($urandom_range(1, 16));
        end
        write_reg(REG_PE_ROWS, 32'(c.pe_rows));
        write_reg(REG_PE_COLS, 32'(c.pe_cols));
        write_reg(REG_SCRATCH, 32'(c.scratch_kib));
        write_reg(REG_CLUSTERS, 32'(c.cluster_count));
      end
      if (ph == NumPhases - 1) steady_tail = 1'b1;
      repeat (LayersPerPhase) begin
        l.func = ($urandom_range(0, 1) == 1) ? OP_GEMM : OP_CONV2D;
        l.is_int8 = 1'($urandom_range(0, 1));
        l.rows_extent = pick_extent();
        l.cols_extent = pick_extent();
        l.search_extent = pick_extent();
        l.out_width = pick_extent();
        l.in_width = pick_extent();
        l.kernel_height = pick_small();
        l.kernel_width = pick_small();
        l.stride_height = pick_small();
        send_layer(l, plan_layer(l));
      end
    end

    drain_plans();
    repeat (150) @(posedge clk_i);
    if (plan_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+src
src/atsp_pkg.sv
src/atsp_mul.sv
src/atsp_div.sv
src/accel_tile_size_planner_top.sv
src/atsp_checker.sv
tb/testbench.sv
